### rtl/core/twmv_pkg.sv
// shared types and constants of the trailing window mean and variance block
`timescale 1ns / 1ps

package twmv_pkg;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int TIME_W      = 32;
  localparam int MEAN_W      = 24;
  localparam int VAR_W       = 38;
  localparam int FRAC_W      = 8;
  localparam int WIDTH_REG_W = 9;
  localparam int STEP_REG_W  = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION_STEP = 1'b1;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 9'd16;
  localparam logic [STEP_REG_W-1:0]  STEP_RESET  = 16'd1;

  // input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]          time_stamp;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [TIME_W-1:0]        time_out;
    logic signed [MEAN_W-1:0] window_mean;
    logic [VAR_W-1:0]         window_variance;
  } out_item_t;

  // configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // front sequencer states
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_UPDATE
  } front_state_e;

  // back sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_START,
    BK_DIV
  } back_state_e;

endpackage

### rtl/core/twmv_fifo.sv
// short job queue between the front and the back part
`timescale 1ns / 1ps

module twmv_fifo #(
  parameter int DATA_W = 100,
  parameter int DEPTH  = 2,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  // status
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/twmv_front.sv
// front part: history ring, running sums, decimation and job issue
`timescale 1ns / 1ps

module twmv_front
  import twmv_pkg::*;
#(
  parameter int MAX_WINDOW = 256,
  localparam int AW    = $clog2(MAX_WINDOW),
  localparam int CW    = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W = 17 + AW,
  localparam int SQ_W  = 31 + AW,
  localparam int JOB_W = TIME_W + SUM_W + SQ_W + CW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             job_valid_o,
  output logic [JOB_W-1:0] job_o,
  input  logic             job_full_i
);

  typedef struct packed {
    logic [TIME_W-1:0]       time_stamp;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq_sum;
    logic [CW-1:0]           count;
  } job_t;

  front_state_e state_q, state_d;

  logic [WIDTH_REG_W-1:0] width_q;
  logic [STEP_REG_W-1:0]  step_q, step_eff;
  logic [CW-1:0]          eff_w, fill_q, fill_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [CW:0]            wp_inc;
  logic [STEP_REG_W-1:0]  dec_q, dec_d;
  logic [STEP_REG_W:0]    dec_inc;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]        sq_q, sq_d;

  logic signed [SAMPLE_W-1:0] sample_q, old_q;
  logic [TIME_W-1:0]          time_q;
  logic [30:0]                samp_sq_q;
  logic signed [31:0]         samp_prod, old_prod;
  logic signed [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

  logic win_full, emit, accept, commit, cfg_clear;
  job_t job;

  // effective window width and decimation step
  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (int'(width_q) > MAX_WINDOW) begin
      eff_w = CW'(MAX_WINDOW);
    end else begin
      eff_w = CW'(width_q);
    end
  end

  assign step_eff  = (step_q == '0) ? STEP_REG_W'(1) : step_q;
  assign win_full  = (fill_q >= eff_w);
  assign emit      = (dec_q == '0);
  assign cfg_clear = cfg_i.we &&
                     ((cfg_i.index == REG_WINDOW_WIDTH) || (cfg_i.index == REG_DECIMATION_STEP));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE:   if (in_valid_i) state_d = FR_READ;
      FR_READ:   state_d = FR_UPDATE;
      FR_UPDATE: if (!emit || !job_full_i) state_d = FR_IDLE;
      default:   state_d = FR_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      FR_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      FR_READ: begin
        in_stall_o = 1'b1;
      end
      FR_UPDATE: begin
        commit = !emit || !job_full_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign job_valid_o = commit && emit;

  // running sums with the oldest sample dropped once the window is full
  assign samp_prod = sample_q * sample_q;
  assign old_prod  = old_q * old_q;

  always_comb begin
    if (win_full) begin
      sum_d  = sum_q - SUM_W'(old_q) + SUM_W'(sample_q);
      sq_d   = sq_q - SQ_W'(old_prod[30:0]) + SQ_W'(samp_sq_q);
      fill_d = fill_q;
    end else begin
      sum_d  = sum_q + SUM_W'(sample_q);
      sq_d   = sq_q + SQ_W'(samp_sq_q);
      fill_d = fill_q + 1'b1;
    end
  end

  // ring pointer and decimation counter
  assign wp_inc  = (CW + 1)'(wp_q) + 1'b1;
  assign wp_d    = (wp_inc >= (CW + 1)'(eff_w)) ? '0 : AW'(wp_inc);
  assign dec_inc = {1'b0, dec_q} + 1'b1;
  assign dec_d   = (dec_inc >= {1'b0, step_eff}) ? '0 : dec_inc[STEP_REG_W-1:0];

  // job towards the back part
  assign job.time_stamp = time_q;
  assign job.sum        = sum_d;
  assign job.sq_sum     = sq_d;
  assign job.count      = fill_d;
  assign job_o          = job;

  // control state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      width_q <= WIDTH_RESET;
      step_q  <= STEP_RESET;
      fill_q  <= '0;
      wp_q    <= '0;
      dec_q   <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_clear) begin
        unique case (cfg_i.index)
          REG_WINDOW_WIDTH:    width_q <= cfg_i.data[WIDTH_REG_W-1:0];
          REG_DECIMATION_STEP: step_q  <= cfg_i.data[STEP_REG_W-1:0];
        endcase
        fill_q <= '0;
        wp_q   <= '0;
        dec_q  <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end else if (commit) begin
        fill_q <= fill_d;
        wp_q   <= wp_d;
        dec_q  <= dec_d;
        sum_q  <= sum_d;
        sq_q   <= sq_d;
      end
    end
  end

  // item payload, oldest sample read and ring write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_item_i.sample_value;
      time_q   <= in_item_i.time_stamp;
    end
    if (state_q == FR_READ) begin
      old_q     <= ring_mem[wp_q];
      samp_sq_q <= samp_prod[30:0];
    end
    if (commit) begin
      ring_mem[wp_q] <= sample_q;
    end
  end

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_w)
    else $error("fill count beyond window width");

  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW + 1)'(wp_q) < (CW + 1)'(eff_w))
    else $error("ring pointer outside window");

  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clear |=> (dec_q == '0) && (sum_q == '0) && (sq_q == '0) && (fill_q == '0))
    else $error("register write did not clear history");

endmodule

### rtl/core/twmv_div.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module twmv_div #(
  parameter int DIVIDEND_W = 56,
  parameter int DIVISOR_W  = 18,
  parameter int QUOT_W     = 38,
  localparam int CNT_W = $clog2(QUOT_W + 1),
  localparam int PAD_W = (DIVIDEND_W > QUOT_W + DIVISOR_W) ? DIVIDEND_W : QUOT_W + DIVISOR_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [QUOT_W-1:0]     quotient_o
);

  logic                 busy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIVISOR_W-1:0] rem_q, rem_d, div_q;
  logic [QUOT_W-1:0]    lo_q, lo_d;
  logic [DIVISOR_W:0]   trial, diff;
  logic [PAD_W-1:0]     ext;
  logic                 ge;

  // the upper part of the dividend is below the divisor since the quotient fits
  assign ext = PAD_W'(dividend_i);

  // one restoring step
  assign trial = {rem_q, lo_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  assign lo_d  = {lo_q[QUOT_W-2:0], ge};

  assign busy_o     = busy_q;
  assign quotient_o = lo_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUOT_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIVISOR_W'(ext >> QUOT_W);
      lo_q  <= ext[QUOT_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == CNT_W'(QUOT_W)))
    else $error("divider did not start");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && (cnt_q == CNT_W'(1))) |=> !busy_q)
    else $error("divider ran past its last step");

endmodule

### rtl/core/twmv_back.sv
// back part: products, two serial divisions and the result register
`timescale 1ns / 1ps

module twmv_back
  import twmv_pkg::*;
#(
  parameter int MAX_WINDOW = 256,
  localparam int AW       = $clog2(MAX_WINDOW),
  localparam int CW       = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W    = 17 + AW,
  localparam int SQ_W     = 31 + AW,
  localparam int SPREAD_W = CW + SQ_W,
  localparam int JOB_W    = TIME_W + SUM_W + SQ_W + CW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  logic [JOB_W-1:0] job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  typedef struct packed {
    logic [TIME_W-1:0]       time_stamp;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq_sum;
    logic [CW-1:0]           count;
  } job_t;

  back_state_e state_q, state_d;
  job_t        job;

  logic [TIME_W-1:0]     time_q;
  logic                  neg_q;
  logic [SUM_W-1:0]      sum_abs, sum_abs_q;
  logic [SQ_W-1:0]       sq_q;
  logic [CW-1:0]         n_q;
  logic [SPREAD_W-1:0]   prod_q, spread;
  logic [2*SUM_W-1:0]    sum2_q;
  logic [2*CW-1:0]       nn_q;

  logic                  div_start, div_done, out_load;
  logic                  mean_busy, var_busy;
  logic [VAR_W-1:0]      mean_quot, var_quot;
  logic [MEAN_W-1:0]     mean_mag, mean_val;

  logic                  out_valid_q;
  out_item_t             out_item_q;

  assign job     = job_i;
  assign sum_abs = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);

  // n*sumsq - sum^2 never goes negative
  assign spread   = prod_q - SPREAD_W'(sum2_q);
  assign div_done = !mean_busy && !var_busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (job_valid_i) state_d = BK_MUL;
      BK_MUL:   state_d = BK_START;
      BK_START: state_d = BK_DIV;
      BK_DIV:   if (div_done && (!out_valid_q || !out_stall_i)) state_d = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    job_pop_o = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      BK_IDLE:  job_pop_o = job_valid_i;
      BK_MUL:   job_pop_o = 1'b0;
      BK_START: div_start = 1'b1;
      BK_DIV:   out_load  = div_done && (!out_valid_q || !out_stall_i);
    endcase
  end

  // mean: |sum| * 256 / n
  twmv_div #(
    .DIVIDEND_W (SUM_W + FRAC_W),
    .DIVISOR_W  (CW),
    .QUOT_W     (VAR_W)
  ) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_abs_q, {FRAC_W{1'b0}}}),
    .divisor_i  (n_q),
    .busy_o     (mean_busy),
    .quotient_o (mean_quot)
  );

  // variance: spread * 256 / n^2
  twmv_div #(
    .DIVIDEND_W (SPREAD_W + FRAC_W),
    .DIVISOR_W  (2 * CW),
    .QUOT_W     (VAR_W)
  ) u_var_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({spread, {FRAC_W{1'b0}}}),
    .divisor_i  (nn_q),
    .busy_o     (var_busy),
    .quotient_o (var_quot)
  );

  // mean truncated toward zero
  assign mean_mag = mean_quot[MEAN_W-1:0];
  assign mean_val = neg_q ? (~mean_mag + 1'b1) : mean_mag;

  // job operands and products
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      time_q    <= job.time_stamp;
      neg_q     <= job.sum[SUM_W-1];
      sum_abs_q <= sum_abs;
      sq_q      <= job.sq_sum;
      n_q       <= job.count;
    end
    if (state_q == BK_MUL) begin
      prod_q <= SPREAD_W'(n_q) * SPREAD_W'(sq_q);
      sum2_q <= (2 * SUM_W)'(sum_abs_q) * (2 * SUM_W)'(sum_abs_q);
      nn_q   <= (2 * CW)'(n_q) * (2 * CW)'(n_q);
    end
    if (out_load) begin
      out_item_q.time_out        <= time_q;
      out_item_q.window_mean     <= $signed(mean_val);
      out_item_q.window_variance <= var_quot;
    end
  end

  // control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/core/trailing_window_mean_variance.sv
// top level of the trailing window mean and variance block
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o    | in_item_i  (sample, time stamp)
//  out     | output    | out_valid_o / out_stall_i  | out_item_o (time, mean, var)
//  cfg     | input     | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// The front part takes an item in three steps: capture, ring read, sum update, and
// takes no new item until they are done. In the back part each emitted item goes
// through two 38-step serial dividers side by side; a 2-entry job queue sits between.
// Reset clears sums, counters and pointers; the ring needs no clearing pass.
// A stalled result stays in the output register while the back part goes on.
`timescale 1ns / 1ps

module trailing_window_mean_variance
  import twmv_pkg::*;
#(
  parameter int MAX_WINDOW  = 256,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 17 + AW;
  localparam int SQ_W  = 31 + AW;
  localparam int JOB_W = TIME_W + SUM_W + SQ_W + CW;

  cfg_wr_t          cfg;
  logic             job_push, job_full, job_valid, job_pop;
  logic [JOB_W-1:0] job_in, job_out;

  // configuration write bundle
  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  // history and decimation
  twmv_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .job_valid_o (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  // job queue
  twmv_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  // mean and variance
  twmv_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### tb/sv/twmv_window_checker.sv
// checker that predicts the window statistics and compares every result item
`timescale 1ns / 1ps

module twmv_window_checker
  import twmv_pkg::*;
#(
  parameter int MAX_WINDOW = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o = 0,
  output int                    pending_o = 0
);

  // own copy of the window state and the registers
  logic signed [SAMPLE_W-1:0] sample_ring [MAX_WINDOW];
  longint                     win_sum = 0;
  longint                     win_sq_sum = 0;
  int unsigned                fill_cnt = 0;
  int unsigned                wr_ptr = 0;
  int unsigned                decim_cnt = 0;
  logic [WIDTH_REG_W-1:0]     width_reg = WIDTH_RESET;
  logic [STEP_REG_W-1:0]      step_reg = STEP_RESET;
  out_item_t                  expected_stats [$];
  int                         fails = 0;

  // a register write starts the history afresh
  task automatic clear_window();
    win_sum    = 0;
    win_sq_sum = 0;
    fill_cnt   = 0;
    wr_ptr     = 0;
    decim_cnt  = 0;
  endtask

  // push the sample into the window and queue the statistics if it is on the grid
  task automatic predict_stats(input in_item_t item);
    int unsigned eff_width;
    int unsigned eff_step;
    int unsigned slot;
    longint      smp;
    longint      oldest;
    longint      n;
    longint      mean_q;
    longint      spread;
    longint      variance_q;
    out_item_t   stats;
    bit          on_grid;

    if (width_reg == '0) begin
      eff_width = 1;
    end else if (width_reg > MAX_WINDOW) begin
      eff_width = MAX_WINDOW;
    end else begin
      eff_width = width_reg;
    end
    eff_step = (step_reg == '0) ? 1 : step_reg;
    slot     = wr_ptr % eff_width;
    smp      = longint'($signed(item.sample_value));

    // drop the oldest sample once the window is full
    if (fill_cnt >= eff_width) begin
      oldest     = longint'(sample_ring[slot]);
      win_sum    = win_sum - oldest;
      win_sq_sum = win_sq_sum - oldest * oldest;
      fill_cnt   = eff_width;
    end else begin
      fill_cnt++;
    end
    sample_ring[slot] = item.sample_value;
    win_sum    = win_sum + smp;
    win_sq_sum = win_sq_sum + smp * smp;
    wr_ptr     = (slot + 1 >= eff_width) ? 0 : slot + 1;

    // decimation grid
    on_grid = (decim_cnt == 0);
    decim_cnt++;
    if (decim_cnt >= eff_step) begin
      decim_cnt = 0;
    end

    if (on_grid) begin
      n          = longint'(fill_cnt);
      mean_q     = (win_sum * 256) / n;
      spread     = n * win_sq_sum - win_sum * win_sum;
      variance_q = (spread * 256) / (n * n);
      stats.time_out        = item.time_stamp;
      stats.window_mean     = mean_q[MEAN_W-1:0];
      stats.window_variance = variance_q[VAR_W-1:0];
      expected_stats = {expected_stats, stats};
    end
  endtask

  // compare a result item with the oldest expectation
  task automatic check_stats(input out_item_t got);
    out_item_t want;

    if (expected_stats.size() == 0) begin
      $display("%0t: unexpected result item, expected none, actual %h", $time, got);
      fails++;
    end else begin
      want = expected_stats.pop_front();
      if (got.time_out !== want.time_out) begin
        $display("%0t: time_out mismatch, expected %h, actual %h",
                 $time, want.time_out, got.time_out);
        fails++;
      end
      if (got.window_mean !== want.window_mean) begin
        $display("%0t: window_mean mismatch, expected %0d, actual %0d",
                 $time, want.window_mean, got.window_mean);
        fails++;
      end
      if (got.window_variance !== want.window_variance) begin
        $display("%0t: window_variance mismatch, expected %0d, actual %0d",
                 $time, want.window_variance, got.window_variance);
        fails++;
      end
    end
  endtask

  // watch the channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = WIDTH_RESET;
      step_reg  = STEP_RESET;
      clear_window();
      expected_stats.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_stats(out_item_i);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_WIDTH: begin
            width_reg = cfg_data_i[WIDTH_REG_W-1:0];
            clear_window();
          end
          REG_DECIMATION_STEP: begin
            step_reg = cfg_data_i[STEP_REG_W-1:0];
            clear_window();
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_stats(in_item_i);
      end
      fail_count_o <= fails;
      pending_o    <= expected_stats.size();
    end
  end

endmodule

### tb/sv/tb_trailing_window_mean_variance.sv
// testbench top: stimulus, register settings and verdict for the window statistics block
`timescale 1ns / 1ps

module tb_trailing_window_mean_variance;
  import twmv_pkg::*;

  localparam int          MAX_WINDOW    = 256;
  localparam int          SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  int                    fail_cnt;
  int                    pending_cnt;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int unsigned           cycle_cnt      = 0;

  trailing_window_mean_variance #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  twmv_window_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_cnt),
    .pending_o   (pending_cnt)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // run-time guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_trailing_window_mean_variance: FAIL");
      $finish;
    end
  end

  // offer one item after a random gap, return once it is taken
  task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] stamp);
    int gap;

    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{sample_value: smp, time_stamp: stamp};
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  // wait for every expected result, then let the front part finish
  task automatic settle();
    @(posedge clk_i);
    while (pending_cnt != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write the chosen registers back to back, then a run of random items
  task automatic run_phase(input bit wr_width, input logic [CFG_DATA_W-1:0] width_val,
                           input bit wr_step, input logic [CFG_DATA_W-1:0] step_val,
                           input int n_items);
    logic signed [SAMPLE_W-1:0] smp;

    settle();
    if (wr_width) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_WINDOW_WIDTH;
      cfg_data_i  <= width_val;
      @(posedge clk_i);
    end
    if (wr_step) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_DECIMATION_STEP;
      cfg_data_i  <= step_val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;

    // mix of extremes, near-extremes, values around zero and full-range noise
    for (int k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 9))
        0:       smp = 16'sh7FFF;
        1:       smp = 16'sh8000;
        2:       smp = 16'($urandom_range(0, 8) - 4);
        3:       smp = 16'(32'h7FF0 + $urandom_range(0, 15));
        4:       smp = 16'(32'h8000 + $urandom_range(0, 15));
        default: smp = 16'($urandom);
      endcase
      send_item(smp, $urandom);
    end
    in_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic signed [SAMPLE_W-1:0] smp;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles lightly, receiver stalls heavily
    send_idle_pct  <= 16;
    recv_stall_pct <= 76;
    @(posedge clk_i);

    // directed: field extremes at the reset settings, then a full window of the minimum
    for (int k = 0; k < 24; k++) begin
      case (k)
        0, 5, 6: smp = 16'sh7FFF;
        2:       smp = 16'sh0000;
        3:       smp = 16'shFFFF;
        4:       smp = 16'sh0001;
        default: smp = 16'sh8000;
      endcase
      send_item(smp, (k == 1) ? 32'hFFFF_FFFF : 32'(k));
    end
    in_valid_i <= 1'b0;

    // zero window and zero step, then the widest window, then a short odd one
    run_phase(1'b1, 16'h0000, 1'b1, 16'h0000, 120);
    run_phase(1'b1, 16'hFFFF, 1'b1, 16'h0001, 420);
    run_phase(1'b1, 16'h0007, 1'b1, 16'h0003, 150);

    // sender idles heavily, receiver stalls lightly
    settle();
    send_idle_pct  <= 76;
    recv_stall_pct <= 16;
    run_phase(1'b1, 16'h0100, 1'b1, 16'h0005, 400);
    run_phase(1'b1, 16'hFE05, 1'b0, '0, 150);
    run_phase(1'b0, '0, 1'b1, 16'hFFFF, 40);

    // no idling on either side
    settle();
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    run_phase(1'b1, 16'h00FF, 1'b1, 16'h0001, 400);
    run_phase(1'b1, 16'h0001, 1'b1, 16'h0007, 100);
    run_phase(1'b1, 16'h0021, 1'b0, '0, 200);

    settle();
    if (fail_cnt == 0) begin
      $display("tb_trailing_window_mean_variance: PASS");
    end else begin
      $display("tb_trailing_window_mean_variance: FAIL");
    end
    $finish;
  end

endmodule
